// ===== hw/rtl/csvfs_pkg.sv =====
package csvfs_pkg;

    // Largest number of fields a record may hold; the index saturates below it.
    localparam int MAX_FIELDS = 256;
    localparam int FIELD_CAP  = ((MAX_FIELDS - 1) < 255) ? (MAX_FIELDS - 1) : 255;

    localparam logic [7:0] QUOTE_CH      = 8'h22;
    localparam logic [7:0] CR_CH         = 8'h0D;
    localparam logic [7:0] LF_CH         = 8'h0A;
    localparam logic [7:0] SEPARATOR_RST = 8'h2C;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_QSEEN  = 3'd3,
        MODE_TAIL   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_beat;

    // One result beat as held in the result register.
    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_char;
        logic [7:0] field_number;
        logic       is_header;
    } t_result;

endpackage

// ===== hw/rtl/csvfs_in_if.sv =====
interface csvfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/csvfs_out_if.sv =====
interface csvfs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic [7:0] field_number;
    logic       is_header;

    modport source (
        output valid, output out_kind, output out_char, output field_number,
        output is_header, input ready
    );
    modport sink (
        input valid, input out_kind, input out_char, input field_number,
        input is_header, output ready
    );
endinterface

// ===== hw/rtl/csv_field_splitter.sv =====
// A beat passes through the input register and then the result register before it leaves.
// Throughput: one input beat per cycle unless stalled; a beat gives zero or one result beat.
// The parser state is updated only as a beat moves from the input to the result register.
// Reset is synchronous and active low: it empties both registers, returns the parser to
// field start of a header record and sets the separator to a comma.
module csv_field_splitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    csvfs_in_if.sink          i_in,
    csvfs_out_if.source       o_out,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data
);

    logic                r_in_valid;
    csvfs_pkg::t_in_beat r_in_beat;
    logic                r_out_valid;
    csvfs_pkg::t_result  r_out;
    logic [7:0]          r_separator;

    logic                out_free;
    logic                step;
    logic                res_valid;
    csvfs_pkg::t_result  res;

    // The result register can load when empty or being drained this cycle.
    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    // Separator register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= csvfs_pkg::SEPARATOR_RST;
        end else if (i_cfg_wr_en) begin
            r_separator <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_beat.in_byte      <= i_in.in_byte;
            r_in_beat.end_of_input <= i_in.end_of_input;
        end
    end

    csvfs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_beat      (r_in_beat),
        .i_separator (r_separator),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_kind     = r_out.out_kind;
    assign o_out.out_char     = r_out.out_char;
    assign o_out.field_number = r_out.field_number;
    assign o_out.is_header    = r_out.is_header;

endmodule

// ===== hw/rtl/csvfs_parser.sv =====
module csvfs_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  csvfs_pkg::t_in_beat i_beat,
    input  logic [7:0]         i_separator,
    output logic               o_res_valid,
    output csvfs_pkg::t_result o_res
);

    csvfs_pkg::t_mode r_mode, n_mode;
    logic             r_prev_cr, n_prev_cr;
    logic             r_has_data, n_has_data;
    logic [7:0]       r_field_cnt, n_field_cnt;
    logic             r_hdr_done, n_hdr_done;

    logic [7:0] c;
    logic       eoi;
    logic       is_eol;
    logic       swallow_lf;
    logic       is_quote;
    logic       is_sep;
    logic       cnt_inc;

    // Byte classification shared by both combinational blocks.
    assign c          = i_beat.in_byte;
    assign eoi        = i_beat.end_of_input;
    assign is_eol     = (c == csvfs_pkg::CR_CH) || (c == csvfs_pkg::LF_CH);
    assign swallow_lf = (c == csvfs_pkg::LF_CH) && r_prev_cr;
    assign is_quote   = (c == csvfs_pkg::QUOTE_CH);
    assign is_sep     = (c == i_separator);
    assign cnt_inc    = (r_field_cnt < 8'(csvfs_pkg::FIELD_CAP));

    // Next state of the mode machine and its counters.
    always_comb begin
        n_mode      = r_mode;
        n_prev_cr   = r_prev_cr;
        n_has_data  = r_has_data;
        n_field_cnt = r_field_cnt;
        n_hdr_done  = r_hdr_done;
        if (eoi) begin
            n_prev_cr   = 1'b0;
            n_mode      = csvfs_pkg::MODE_START;
            n_has_data  = 1'b0;
            n_field_cnt = 8'd0;
            n_hdr_done  = 1'b1;
        end else if (is_eol) begin
            n_prev_cr = (c == csvfs_pkg::CR_CH);
            if (!swallow_lf) begin
                n_mode      = csvfs_pkg::MODE_START;
                n_has_data  = 1'b0;
                n_field_cnt = 8'd0;
                n_hdr_done  = 1'b1;
            end
        end else begin
            n_prev_cr  = 1'b0;
            n_has_data = 1'b1;
            unique case (r_mode)
                csvfs_pkg::MODE_START: begin
                    if (is_quote) begin
                        n_mode = csvfs_pkg::MODE_QUOTED;
                    end else if (is_sep) begin
                        n_mode = csvfs_pkg::MODE_START;
                        if (cnt_inc) n_field_cnt = r_field_cnt + 8'd1;
                    end else begin
                        n_mode = csvfs_pkg::MODE_PLAIN;
                    end
                end
                csvfs_pkg::MODE_QUOTED: begin
                    if (is_quote) n_mode = csvfs_pkg::MODE_QSEEN;
                end
                csvfs_pkg::MODE_QSEEN: begin
                    if (is_quote) begin
                        n_mode = csvfs_pkg::MODE_QUOTED;
                    end else if (is_sep) begin
                        n_mode = csvfs_pkg::MODE_START;
                        if (cnt_inc) n_field_cnt = r_field_cnt + 8'd1;
                    end else begin
                        n_mode = csvfs_pkg::MODE_TAIL;
                    end
                end
                default: begin
                    // Plain field or copied tail after a closing quote.
                    if (is_sep) begin
                        n_mode = csvfs_pkg::MODE_START;
                        if (cnt_inc) n_field_cnt = r_field_cnt + 8'd1;
                    end
                end
            endcase
        end
    end

    // Result of the current beat, if it produces one.
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.out_kind     = csvfs_pkg::KIND_DATA;
        o_res.out_char     = 8'd0;
        o_res.field_number = r_field_cnt;
        o_res.is_header    = !r_hdr_done;
        if (eoi) begin
            o_res_valid    = r_has_data;
            o_res.out_kind = csvfs_pkg::KIND_RECORD;
        end else if (is_eol) begin
            o_res_valid = !swallow_lf;
            if (r_has_data) begin
                o_res.out_kind = csvfs_pkg::KIND_RECORD;
            end else begin
                o_res.out_kind     = csvfs_pkg::KIND_EMPTY;
                o_res.field_number = 8'd0;
            end
        end else begin
            unique case (r_mode)
                csvfs_pkg::MODE_START,
                csvfs_pkg::MODE_QSEEN: begin
                    // A quote here opens a field silently in start mode; after a closing quote,
                    // a second quote is a doubled quote, which gives one quote.
                    if (is_quote) begin
                        o_res_valid    = (r_mode == csvfs_pkg::MODE_QSEEN);
                        o_res.out_char = c;
                    end else if (is_sep) begin
                        o_res_valid    = 1'b1;
                        o_res.out_kind = csvfs_pkg::KIND_FIELD;
                    end else begin
                        o_res_valid    = 1'b1;
                        o_res.out_char = c;
                    end
                end
                csvfs_pkg::MODE_QUOTED: begin
                    o_res_valid    = !is_quote;
                    o_res.out_char = c;
                end
                default: begin
                    o_res_valid = 1'b1;
                    if (is_sep) begin
                        o_res.out_kind = csvfs_pkg::KIND_FIELD;
                    end else begin
                        o_res.out_char = c;
                    end
                end
            endcase
        end
    end

    // State registers advance once per beat taken from the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= csvfs_pkg::MODE_START;
            r_prev_cr   <= 1'b0;
            r_has_data  <= 1'b0;
            r_field_cnt <= 8'd0;
            r_hdr_done  <= 1'b0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_prev_cr   <= n_prev_cr;
            r_has_data  <= n_has_data;
            r_field_cnt <= n_field_cnt;
            r_hdr_done  <= n_hdr_done;
        end
    end

endmodule
